// ===== hw/rtl/lzf_pkg.sv =====
// Shared types and constants of the LZF stream decompressor.
// Depends on nothing; the command FIFO, front, back, top and testbench import it.
package lzf_pkg;

   localparam int HistoryDepthDefault   = 8192;
   localparam int BytesPerResultDefault = 8;
   localparam int CountWidth = 24;
   localparam int DistWidth  = 14;
   localparam int RefLenWidth = 9;
   localparam int LitMaxCtrl = 32;
   localparam int CmdFifoDepth = 4;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusOverflow = 2'd1;
   localparam logic [1:0] StatusBadRef   = 2'd2;
   localparam logic [1:0] StatusTrunc    = 2'd3;

   typedef enum logic [1:0] {
      PH_CTRL, PH_LIT, PH_EXT, PH_OFF
   } phase_type;

   typedef enum logic [1:0] {
      CMD_LIT, CMD_COPY, CMD_END
   } cmd_op_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_LIT, BK_RD, BK_WR, BK_FLUSH
   } back_state_type;

   // One parsed step handed from the front to the back.
   typedef struct packed {
      cmd_op_type             op;
      logic [7:0]             data;
      logic [DistWidth-1:0]   ref_dist;
      logic [RefLenWidth:0]   cnt;
      logic                   done;
      logic [1:0]             status;
      logic [CountWidth-1:0]  base;
   } cmd_type;

endpackage

// ===== hw/rtl/lzf_req_if.sv =====
// Input channel of the decompressor: one compressed byte per transfer.
// Depends on nothing.
interface lzf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   logic       start_block;

   modport source (output valid, output in_byte, output in_last, output start_block,
                   input ready);
   modport sink (input valid, input in_byte, input in_last, input start_block,
                 output ready);
endinterface

// ===== hw/rtl/lzf_rsp_if.sv =====
// Result channel of the decompressor: up to eight bytes per transfer.
// Depends on nothing.
interface lzf_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_bytes;
   logic [3:0]  byte_count;
   logic        out_last;
   logic [1:0]  status;
   logic [23:0] total_length;

   modport source (output valid, output out_bytes, output byte_count, output out_last,
                   output status, output total_length, input ready);
   modport sink (input valid, input out_bytes, input byte_count, input out_last,
                 input status, input total_length, output ready);
endinterface

// ===== hw/rtl/lzf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lzf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/lzf_cmd_fifo.sv =====
// Short command queue between the parser front and the copy back end.
// Depends on lzf_pkg for the command type.
module lzf_cmd_fifo
   import lzf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);
   localparam int PtrWidth = $clog2(CmdFifoDepth);

   cmd_type               slot_ff [CmdFifoDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]     count_ff, count_in;

   assign full    = (count_ff == (PtrWidth+1)'(CmdFifoDepth));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrWidth'(push);
      rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
      count_in  = count_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

// ===== hw/rtl/lzf_front.sv =====
// Parser front: takes compressed bytes, checks limits and emits commands.
// Depends on lzf_pkg and lzf_req_if.
module lzf_front
   import lzf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lzf_req_if.sink               req,
   input  logic [CountWidth-1:0] dest_limit,
   output logic                  push,
   output cmd_type               push_cmd,
   input  logic                  full
);
   phase_type               phase_ff, phase_in;
   logic [4:0]              lit_left_ff, lit_left_in;
   logic [RefLenWidth-1:0]  ref_len_ff, ref_len_in;
   logic [4:0]              off_hi_ff, off_hi_in;
   logic [CountWidth-1:0]   prod_ff, prod_in;
   logic                    halted_ff, halted_in;

   logic                    accept;
   phase_type               ph_e;
   logic [4:0]              lit_e;
   logic [RefLenWidth-1:0]  len_e;
   logic [4:0]              off_e;
   logic [CountWidth-1:0]   prod_e;
   logic                    halted_e;
   logic [CountWidth:0]     lit_sum;
   logic [CountWidth:0]     ref_sum;
   logic [RefLenWidth:0]    copy_cnt;
   logic [DistWidth-1:0]    ref_dist;
   logic                    done;
   logic                    item_done;
   logic                    emit;

   assign req.ready = !full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      // Start of block clears the parser ahead of this byte.
      ph_e     = req.start_block ? PH_CTRL : phase_ff;
      lit_e    = req.start_block ? '0 : lit_left_ff;
      len_e    = req.start_block ? '0 : ref_len_ff;
      off_e    = req.start_block ? '0 : off_hi_ff;
      prod_e   = req.start_block ? '0 : prod_ff;
      halted_e = req.start_block ? 1'b0 : halted_ff;

      lit_sum  = {1'b0, prod_e} + (CountWidth+1)'(req.in_byte) + (CountWidth+1)'(1);
      copy_cnt = {1'b0, len_e} + (RefLenWidth+1)'(2);
      ref_sum  = {1'b0, prod_e} + (CountWidth+1)'(copy_cnt);
      ref_dist = {off_e, req.in_byte} + DistWidth'(1);

      phase_in    = ph_e;
      lit_left_in = lit_e;
      ref_len_in  = len_e;
      off_hi_in   = off_e;
      prod_in     = prod_e;
      halted_in   = halted_e;
      done        = 1'b0;
      item_done   = 1'b0;
      emit        = 1'b0;

      push_cmd          = '0;
      push_cmd.op       = CMD_END;
      push_cmd.data     = req.in_byte;
      push_cmd.ref_dist = ref_dist;
      push_cmd.cnt      = copy_cnt;
      push_cmd.status   = StatusOk;
      push_cmd.base     = prod_e;

      if (!halted_e) begin
         unique case (ph_e)
            PH_CTRL: begin
               if (req.in_byte < 8'(LitMaxCtrl)) begin
                  if (lit_sum > {1'b0, dest_limit}) begin
                     push_cmd.status = StatusOverflow;
                     done = 1'b1;
                  end else begin
                     lit_left_in = req.in_byte[4:0];
                     phase_in    = PH_LIT;
                     if (req.in_last) begin
                        push_cmd.status = StatusTrunc;
                        done = 1'b1;
                     end
                  end
               end else begin
                  ref_len_in = RefLenWidth'(req.in_byte[7:5]);
                  off_hi_in  = req.in_byte[4:0];
                  phase_in   = (req.in_byte[7:5] == 3'd7) ? PH_EXT : PH_OFF;
                  if (req.in_last) begin
                     push_cmd.status = StatusTrunc;
                     done = 1'b1;
                  end
               end
            end
            PH_LIT: begin
               push_cmd.op = CMD_LIT;
               emit        = 1'b1;
               prod_in     = prod_e + CountWidth'(1);
               if (lit_e == '0) begin
                  phase_in  = PH_CTRL;
                  item_done = 1'b1;
               end else begin
                  lit_left_in = lit_e - 5'd1;
                  if (req.in_last) begin
                     push_cmd.status = StatusTrunc;
                     done = 1'b1;
                  end
               end
            end
            PH_EXT: begin
               ref_len_in = len_e + RefLenWidth'(req.in_byte);
               phase_in   = PH_OFF;
               if (req.in_last) begin
                  push_cmd.status = StatusTrunc;
                  done = 1'b1;
               end
            end
            PH_OFF: begin
               if (ref_sum > {1'b0, dest_limit}) begin
                  push_cmd.status = StatusOverflow;
                  done = 1'b1;
               end else if ({{(CountWidth-DistWidth){1'b0}}, ref_dist} > prod_e) begin
                  push_cmd.status = StatusBadRef;
                  done = 1'b1;
               end else begin
                  push_cmd.op = CMD_COPY;
                  emit        = 1'b1;
                  prod_in     = ref_sum[CountWidth-1:0];
                  phase_in    = PH_CTRL;
                  item_done   = 1'b1;
               end
            end
            default: begin
               phase_in = PH_CTRL;
            end
         endcase

         // A finished item ends the block on the last byte or at the limit.
         if (item_done && (req.in_last || prod_in >= dest_limit)) begin
            push_cmd.status = StatusOk;
            done = 1'b1;
         end
         if (done) begin
            halted_in = 1'b1;
            phase_in  = PH_CTRL;
            emit      = 1'b1;
         end
      end
      push_cmd.done = done;
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CTRL;
         lit_left_ff <= '0;
         ref_len_ff  <= '0;
         off_hi_ff   <= '0;
         prod_ff     <= '0;
         halted_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         lit_left_ff <= lit_left_in;
         ref_len_ff  <= ref_len_in;
         off_hi_ff   <= off_hi_in;
         prod_ff     <= prod_in;
         halted_ff   <= halted_in;
      end
   end
endmodule

// ===== hw/rtl/lzf_back.sv =====
// Back end: carries out literal and copy commands, keeps the history RAM
// and packs output bytes into results. Depends on lzf_pkg, lzf_ram, lzf_rsp_if.
module lzf_back
   import lzf_pkg::*;
#(
   parameter int HISTORY_DEPTH    = HistoryDepthDefault,
   parameter int BYTES_PER_RESULT = BytesPerResultDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     empty,
   input  cmd_type  pop_cmd,
   output logic     pop,
   lzf_rsp_if.source rsp
);
   localparam int AddrWidth = $clog2(HISTORY_DEPTH);
   localparam int AccWidth  = 8 * BYTES_PER_RESULT;

   back_state_type          state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [RefLenWidth:0]    left_ff, left_in;
   logic [CountWidth-1:0]   ptr_ff, ptr_in;
   logic [AccWidth-1:0]     acc_ff, acc_in;
   logic [3:0]              acc_n_ff, acc_n_in;

   logic                    out_valid_ff, out_valid_in;
   logic [63:0]             out_bytes_ff, out_bytes_in;
   logic [3:0]              out_count_ff, out_count_in;
   logic                    out_last_ff, out_last_in;
   logic [1:0]              out_status_ff, out_status_in;
   logic [CountWidth-1:0]   out_total_ff, out_total_in;

   logic                    out_free;
   logic                    wr_en;
   logic [7:0]              wr_data;
   logic                    rd_en;
   logic [CountWidth-1:0]   src;
   logic [7:0]              rd_data;

   lzf_ram #(
      .WIDTH (8),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff[AddrWidth-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (src[AddrWidth-1:0]),
      .rd_data (rd_data)
   );

   assign src      = ptr_ff - CountWidth'(cmd_ff.ref_dist);
   assign out_free = !out_valid_ff || rsp.ready;

   // Command sequencer and output packing.
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      left_in   = left_ff;
      ptr_in    = ptr_ff;
      acc_in    = acc_ff;
      acc_n_in  = acc_n_ff;
      pop       = 1'b0;
      wr_en     = 1'b0;
      wr_data   = rd_data;
      rd_en     = 1'b0;

      out_valid_in  = out_valid_ff && !rsp.ready;
      out_bytes_in  = out_bytes_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_total_in  = out_total_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               cmd_in   = pop_cmd;
               ptr_in   = pop_cmd.base;
               acc_in   = '0;
               acc_n_in = '0;
               left_in  = (pop_cmd.op == CMD_COPY) ? pop_cmd.cnt : '0;
               unique case (pop_cmd.op)
                  CMD_LIT:  state_in = BK_LIT;
                  CMD_COPY: state_in = BK_RD;
                  default:  state_in = BK_FLUSH;
               endcase
            end
         end
         BK_LIT: begin
            wr_en    = 1'b1;
            wr_data  = cmd_ff.data;
            acc_in[8*acc_n_ff +: 8] = cmd_ff.data;
            acc_n_in = acc_n_ff + 4'd1;
            ptr_in   = ptr_ff + CountWidth'(1);
            state_in = BK_FLUSH;
         end
         BK_RD: begin
            rd_en    = 1'b1;
            state_in = BK_WR;
         end
         BK_WR: begin
            wr_en    = 1'b1;
            acc_in[8*acc_n_ff +: 8] = rd_data;
            acc_n_in = acc_n_ff + 4'd1;
            ptr_in   = ptr_ff + CountWidth'(1);
            left_in  = left_ff - (RefLenWidth+1)'(1);
            if (acc_n_in == 4'(BYTES_PER_RESULT) || left_in == '0) begin
               state_in = BK_FLUSH;
            end else begin
               state_in = BK_RD;
            end
         end
         BK_FLUSH: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_bytes_in  = 64'(acc_ff);
               out_count_in  = acc_n_ff;
               out_last_in   = cmd_ff.done && (left_ff == '0);
               out_status_in = (cmd_ff.done && (left_ff == '0)) ? cmd_ff.status : StatusOk;
               out_total_in  = ptr_ff;
               acc_in        = '0;
               acc_n_in      = '0;
               state_in      = (left_ff == '0) ? BK_IDLE : BK_RD;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      left_ff       <= left_in;
      ptr_ff        <= ptr_in;
      acc_ff        <= acc_in;
      acc_n_ff      <= acc_n_in;
      out_bytes_ff  <= out_bytes_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      out_total_ff  <= out_total_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.out_bytes    = out_bytes_ff;
   assign rsp.byte_count   = out_count_ff;
   assign rsp.out_last     = out_last_ff;
   assign rsp.status       = out_status_ff;
   assign rsp.total_length = out_total_ff;
endmodule

// ===== hw/rtl/lzf_stream_decompressor.sv =====
// Channel     | Direction | Carries
// req_port    | in        | in_byte, in_last, start_block (one compressed byte)
// rsp_port    | out       | out_bytes, byte_count, out_last, status, total_length
// csr_wr_*    | in        | dest_limit, 24 bits, write only
//
// A byte that yields no output is taken while the queue has room; a literal byte
// passes through the LIT and FLUSH states of the back end, and a copy alternates
// RD and WR per byte and FLUSH per result. A four-entry command queue lets
// the parser keep taking bytes while the back end copies. Reset (synchronous)
// clears the parser, the queue and the output register; the history RAM is not
// cleared. Output stalls back up through the queue to req_port.ready.
module lzf_stream_decompressor
   import lzf_pkg::*;
#(
   parameter int HISTORY_DEPTH    = HistoryDepthDefault,
   parameter int BYTES_PER_RESULT = BytesPerResultDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   lzf_req_if.sink               req_port,
   lzf_rsp_if.source             rsp_port,
   input  logic                  csr_wr_en,
   input  logic [CountWidth-1:0] csr_wr_data
);
   logic [CountWidth-1:0] dest_limit_ff;
   logic                  push;
   logic                  pop;
   logic                  full;
   logic                  empty;
   cmd_type               push_cmd;
   cmd_type               pop_cmd;

   // Destination limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_limit_ff <= '0;
      end else if (csr_wr_en) begin
         dest_limit_ff <= csr_wr_data;
      end
   end

   lzf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .dest_limit (dest_limit_ff),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full)
   );

   lzf_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (empty)
   );

   lzf_back #(
      .HISTORY_DEPTH    (HISTORY_DEPTH),
      .BYTES_PER_RESULT (BYTES_PER_RESULT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .empty   (empty),
      .pop_cmd (pop_cmd),
      .pop     (pop),
      .rsp     (rsp_port)
   );
endmodule

// ===== tb/tb_lzf_stream_decompressor.sv =====
// Self-checking testbench for lzf_stream_decompressor: compressed streams go in
// and each result is checked against a cycle-free predictor of the decoder.
// Depends on lzf_pkg, lzf_req_if, lzf_rsp_if and the decompressor RTL.
module tb_lzf_stream_decompressor;
   import lzf_pkg::*;

   typedef struct {
      logic [63:0] out_bytes;
      logic [3:0]  byte_count;
      logic        out_last;
      logic [1:0]  status;
      logic [23:0] total_length;
   } out_word_type;

   // One row of the directed stream; a row may instead set the byte limit.
   typedef struct {
      bit          is_cfg;
      logic [23:0] cfg_val;
      bit          start;
      bit          last;
      logic [7:0]  data;
      bit          typed;
      logic [1:0]  exp_status;
   } row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CountWidth-1:0] csr_wr_data;

   lzf_req_if req_ch ();
   lzf_rsp_if rsp_ch ();

   lzf_stream_decompressor dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_ch),
      .rsp_port    (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Decoder image kept by the testbench.
   phase_type   dec_phase;
   logic [4:0]  lit_due;
   logic [8:0]  copy_len;
   logic [4:0]  dist_high;
   logic [7:0]  window [HistoryDepthDefault];
   logic [23:0] made_count;
   bit          stopped;
   logic [23:0] byte_limit;

   out_word_type pending_words [$];
   out_word_type step_words [$];
   int        fail_count = 0;
   int        tx_idle_pct = 0;
   int        rx_stall_pct = 0;
   int        hold_left = 0;
   int        gen_made;

   // Stores one decoded byte into the window and the step's byte list.
   task automatic emit_byte(input logic [7:0] v, inout logic [7:0] made[$]);
      window[made_count[12:0]] = v;
      made_count = made_count + 24'd1;
      made.push_back(v);
   endtask

   // Decodes one accepted byte and leaves the results it causes in step_words.
   task automatic decode_byte(input logic [7:0] b, input bit last, input bit st);
      logic [7:0]  made [$];
      bit          done;
      bit          item_done;
      logic [1:0]  stat;
      int          ref_dist;
      int          cnt;
      int          nres;
      int          pos;
      int          take;
      logic [23:0] base;
      out_word_type w;
      done = 0;
      item_done = 0;
      stat = StatusOk;
      step_words.delete();
      if (st) begin
         dec_phase = PH_CTRL;
         lit_due = '0;
         copy_len = '0;
         dist_high = '0;
         made_count = '0;
         stopped = 0;
      end
      if (stopped) return;
      case (dec_phase)
         PH_CTRL: begin
            if (b < LitMaxCtrl) begin
               if (int'(made_count) + int'(b) + 1 > int'(byte_limit)) begin
                  stat = StatusOverflow;
                  done = 1;
               end else begin
                  lit_due = b[4:0];
                  dec_phase = PH_LIT;
                  if (last) begin
                     stat = StatusTrunc;
                     done = 1;
                  end
               end
            end else begin
               copy_len = {6'd0, b[7:5]};
               dist_high = b[4:0];
               dec_phase = (b[7:5] == 3'd7) ? PH_EXT : PH_OFF;
               if (last) begin
                  stat = StatusTrunc;
                  done = 1;
               end
            end
         end
         PH_LIT: begin
            emit_byte(b, made);
            if (lit_due == 0) begin
               dec_phase = PH_CTRL;
               item_done = 1;
            end else begin
               lit_due = lit_due - 5'd1;
               if (last) begin
                  stat = StatusTrunc;
                  done = 1;
               end
            end
         end
         PH_EXT: begin
            copy_len = copy_len + {1'b0, b};
            dec_phase = PH_OFF;
            if (last) begin
               stat = StatusTrunc;
               done = 1;
            end
         end
         default: begin
            ref_dist = int'(dist_high) * 256 + int'(b) + 1;
            cnt = int'(copy_len) + 2;
            if (int'(made_count) + cnt > int'(byte_limit)) begin
               stat = StatusOverflow;
               done = 1;
            end else if (ref_dist > int'(made_count)) begin
               stat = StatusBadRef;
               done = 1;
            end else begin
               // Byte by byte, so an overlapping copy repeats recent output.
               for (int i = 0; i < cnt; i++)
                  emit_byte(window[13'(made_count - 24'(ref_dist))], made);
               dec_phase = PH_CTRL;
               item_done = 1;
            end
         end
      endcase
      if (item_done && (last || made_count >= byte_limit)) begin
         stat = StatusOk;
         done = 1;
      end
      if (done) begin
         stopped = 1;
         dec_phase = PH_CTRL;
      end
      // Pack the produced bytes, eight to a result.
      nres = (made.size() + 7) / 8;
      if (done && nres == 0) nres = 1;
      base = made_count - 24'(made.size());
      pos = 0;
      for (int k = 0; k < nres; k++) begin
         take = made.size() - pos;
         if (take > 8) take = 8;
         w.out_bytes = '0;
         for (int j = 0; j < take; j++) w.out_bytes[8*j +: 8] = made[pos + j];
         pos += take;
         w.byte_count = 4'(take);
         w.out_last = done && (k + 1 == nres);
         w.status = w.out_last ? stat : StatusOk;
         w.total_length = base + 24'(pos);
         step_words.push_back(w);
      end
   endtask

   // Offers one byte, waits for its transfer, then predicts its results.
   task automatic send_byte(input logic [7:0] b, input bit last, input bit st,
                            input bit typed = 0, input logic [1:0] exp_status = 0);
      out_word_type w;
      while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= last;
      req_ch.start_block <= st;
      do @(posedge clock); while (!req_ch.ready);
      decode_byte(b, last, st);
      if (typed) begin
         w.out_bytes = '0;
         w.byte_count = '0;
         w.out_last = 1'b1;
         w.status = exp_status;
         w.total_length = '0;
         pending_words.push_back(w);
      end else begin
         foreach (step_words[i]) pending_words.push_back(step_words[i]);
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_limit(input logic [23:0] v);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      byte_limit = v;
   endtask

   // Builds one block: mostly valid literal runs and references, sometimes
   // a bad distance, noise, or an end marker in the middle of an item.
   task automatic send_block(inout int sent);
      logic [7:0] bytes [$];
      int items;
      int r;
      int run;
      int len;
      int ref_dist;
      int cut;
      items = $urandom_range(1, 5);
      gen_made = 0;
      for (int n = 0; n < items; n++) begin
         r = $urandom_range(0, 99);
         if (r < 50 || gen_made == 0) begin
            run = ($urandom_range(0, 9) == 0) ? 31 : $urandom_range(0, 7);
            bytes.push_back(8'(run));
            for (int i = 0; i <= run; i++) bytes.push_back(8'($urandom_range(0, 255)));
            gen_made += run + 1;
         end else if (r < 92) begin
            len = $urandom_range(1, 7);
            ref_dist = $urandom_range(1, (gen_made < 8192) ? gen_made : 8192);
            if ($urandom_range(0, 19) == 0 && gen_made < 8192) ref_dist = gen_made + 1;
            bytes.push_back({3'(len), 5'((ref_dist - 1) >> 8)});
            if (len == 7) begin
               run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 15);
               bytes.push_back(8'(run));
               len += run;
            end
            bytes.push_back(8'(ref_dist - 1));
            gen_made += len + 2;
         end else begin
            bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      cut = bytes.size() - 1;
      if ($urandom_range(0, 6) == 0) cut = $urandom_range(0, cut);
      for (int i = 0; i <= cut; i++) begin
         send_byte(bytes[i], i == cut, i == 0);
         sent++;
      end
   endtask

   // Result side: random stalls, plus a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // Compares each result transfer with the oldest expectation.
   always @(posedge clock) begin
      out_word_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result: out_bytes=%h", rsp_ch.out_bytes);
            fail_count++;
         end else begin
            e = pending_words.pop_front();
            if (rsp_ch.out_bytes !== e.out_bytes) begin
               $error("out_bytes: expected %h, got %h", e.out_bytes, rsp_ch.out_bytes);
               fail_count++;
            end
            if (rsp_ch.byte_count !== e.byte_count) begin
               $error("byte_count: expected %0d, got %0d", e.byte_count, rsp_ch.byte_count);
               fail_count++;
            end
            if (rsp_ch.out_last !== e.out_last) begin
               $error("out_last: expected %0d, got %0d", e.out_last, rsp_ch.out_last);
               fail_count++;
            end
            if (rsp_ch.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_ch.status);
               fail_count++;
            end
            if (rsp_ch.total_length !== e.total_length) begin
               $error("total_length: expected %0d, got %0d", e.total_length,
                      rsp_ch.total_length);
               fail_count++;
            end
         end
      end
   end

   // Directed stream: extremes of the limit, every item kind and every status.
   row_type directed [] = '{
      '{1, 24'd0,        0, 0, 8'h00, 0, StatusOk},
      '{0, 24'd0,        1, 0, 8'h00, 1, StatusOverflow},
      '{0, 24'd0,        0, 0, 8'h05, 0, StatusOk},
      '{1, 24'hFFFFFF,   0, 0, 8'h00, 0, StatusOk},
      '{0, 24'd0,        1, 1, 8'h00, 1, StatusTrunc},
      '{0, 24'd0,        1, 0, 8'h20, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'h00, 1, StatusBadRef},
      '{0, 24'd0,        1, 0, 8'h02, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'hFF, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'h00, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'h80, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'hE0, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'hFF, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'h02, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'h1F, 0, StatusOk},
      '{0, 24'd0,        0, 1, 8'h7E, 0, StatusOk},
      '{0, 24'd0,        1, 0, 8'hFF, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'h10, 0, StatusOk},
      '{0, 24'd0,        0, 1, 8'hFF, 1, StatusBadRef},
      '{0, 24'd0,        1, 0, 8'h00, 0, StatusOk},
      '{0, 24'd0,        0, 1, 8'h11, 0, StatusOk},
      '{1, 24'd5,        0, 0, 8'h00, 0, StatusOk},
      '{0, 24'd0,        1, 0, 8'h01, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'hAA, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'h55, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'h60, 0, StatusOk},
      '{0, 24'd0,        0, 0, 8'h01, 0, StatusOk}
   };

   logic [23:0] phase_limit [5] = '{24'hFFFFFF, 24'd40, 24'd150, 24'd9, 24'hFFFFFF};
   int          phase_tx [5]    = '{0, 61, 0, 30, 0};
   int          phase_rx [5]    = '{0, 0, 61, 30, 0};

   initial begin
      int sent;
      reset = 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.in_byte <= '0;
      req_ch.in_last <= 1'b0;
      req_ch.start_block <= 1'b0;
      byte_limit = '0;
      dec_phase = PH_CTRL;
      lit_due = '0;
      copy_len = '0;
      dist_high = '0;
      made_count = '0;
      stopped = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_cfg)
            write_limit(directed[i].cfg_val);
         else
            send_byte(directed[i].data, directed[i].last, directed[i].start,
                      directed[i].typed, directed[i].exp_status);
      end

      // Random phases with their own limit and idling pattern.
      for (int p = 0; p < 5; p++) begin
         write_limit(phase_limit[p]);
         tx_idle_pct = phase_tx[p];
         rx_stall_pct = phase_rx[p];
         if (p == 4) hold_left = 400;
         sent = 0;
         while (sent < 42) send_block(sent);
      end

      wait_idle();
      if (fail_count == 0)
         $display("lzf_stream_decompressor: match");
      else
         $display("lzf_stream_decompressor: mismatch");
      $finish;
   end

   initial begin
      #4000000;
      $display("lzf_stream_decompressor: mismatch");
      $finish;
   end

endmodule

// ===== lzf_stream_decompressor.f =====
hw/rtl/lzf_pkg.sv
hw/rtl/lzf_req_if.sv
hw/rtl/lzf_rsp_if.sv
hw/rtl/lzf_ram.sv
hw/rtl/lzf_cmd_fifo.sv
hw/rtl/lzf_front.sv
hw/rtl/lzf_back.sv
hw/rtl/lzf_stream_decompressor.sv
tb/tb_lzf_stream_decompressor.sv
